FILE: rtl/lpsfsm_pkg.sv
package lpsfsm_pkg;

  // Link controller states. The link-status wait state is coded as 7.
  typedef enum logic [2:0] {
    ST_IDLE        = 3'd0,
    ST_UNCONF_TXW  = 3'd1,
    ST_RESET_TXW   = 3'd2,
    ST_DATA_TXW    = 3'd3,
    ST_STATUS_TXW  = 3'd4,
    ST_RESET_WAIT  = 3'd5,
    ST_DATA_WAIT   = 3'd6,
    ST_STATUS_WAIT = 3'd7
  } link_state_e;

  // Event codes carried on the func field.
  typedef enum logic [3:0] {
    EV_SEND_CONF   = 4'd0,
    EV_SEND_UNCONF = 4'd1,
    EV_REQ_STATUS  = 4'd2,
    EV_TX_DONE     = 4'd3,
    EV_ACK         = 4'd4,
    EV_NACK        = 4'd5,
    EV_LINK_STATUS = 4'd6,
    EV_NOT_SUPP    = 4'd7,
    EV_TIMEOUT     = 4'd8
  } link_event_e;

  typedef enum logic [2:0] {
    FR_NONE   = 3'd0,
    FR_UNCONF = 3'd1,
    FR_CONF   = 3'd2,
    FR_RESET  = 3'd3,
    FR_STATUS = 3'd4
  } frame_cmd_e;

  typedef enum logic [1:0] {
    TM_NONE   = 2'd0,
    TM_START  = 2'd1,
    TM_CANCEL = 2'd2
  } timer_cmd_e;

  typedef enum logic [1:0] {
    SD_NONE = 2'd0,
    SD_OK   = 2'd1,
    SD_FAIL = 2'd2
  } send_done_e;

  typedef enum logic [2:0] {
    KA_NONE      = 3'd0,
    KA_INIT      = 3'd1,
    KA_COMPLETE  = 3'd2,
    KA_FAILED    = 3'd3,
    KA_TIMED_OUT = 3'd4
  } keepalive_e;

  typedef enum logic [1:0] {
    LN_NONE    = 2'd0,
    LN_RESET   = 2'd1,
    LN_UNRESET = 2'd2
  } link_notice_e;

  // One command word produced per event.
  typedef struct packed {
    link_state_e  state_after;
    frame_cmd_e   frame_cmd;
    logic         frame_count_bit;
    timer_cmd_e   timer_cmd;
    send_done_e   send_done;
    keepalive_e   keepalive_event;
    link_notice_e link_notice;
    logic         unexpected;
  } link_result_t;

endpackage

FILE: rtl/link_primary_station_fsm.sv
// Primary-station link controller. Each accepted event transaction yields
// exactly one command word, and the block takes a new event every clock
// cycle while in_stall_o is low. An accepted event waits in the input
// register; when it moves on, the next-state decode writes the result
// register and the controller state together. A stalled result holds the
// input register, so at most two transactions are in flight and in_stall_o
// rises only while both registers are full. The link-status wait state is
// reported on state_after_o as code 7. max_retries is written through the
// configuration channel only while the input register is empty.
module link_primary_station_fsm (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration write channel
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  // Event channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [3:0] func_i,
  input  logic       success_i,
  input  logic       rx_buffer_full_i,
  input  logic       more_segments_i,
  // Command channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] state_after_o,
  output logic [2:0] frame_cmd_o,
  output logic       frame_count_bit_o,
  output logic [1:0] timer_cmd_o,
  output logic [1:0] send_done_o,
  output logic [2:0] keepalive_event_o,
  output logic [1:0] link_notice_o,
  output logic       unexpected_o
);
  import lpsfsm_pkg::*;

  // Configuration and controller state.
  logic [7:0]   max_retries_q;
  link_state_e  state_q, state_d;
  logic         remote_reset_q, remote_reset_d;
  logic         count_bit_q, count_bit_d;
  logic [7:0]   retries_q, retries_d;

  // Input register.
  logic         s1_valid_q;
  link_event_e  s1_event_q;
  logic         s1_success_q;
  logic         s1_full_q;
  logic         s1_more_q;

  // Result register.
  logic         out_valid_q;
  link_result_t res_q, res_d;

  logic         advance;
  logic         in_accept;

  // Handshake: the input register moves on whenever the result slot frees up.
  assign advance     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && !advance;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = !s1_valid_q;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_retries_q <= 8'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_retries_q <= cfg_data_i;
    end
  end

  // Input register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_event_q   <= link_event_e'(func_i);
      s1_success_q <= success_i;
      s1_full_q    <= rx_buffer_full_i;
      s1_more_q    <= more_segments_i;
    end
  end

  // Controller state register, updated as each event is decoded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      remote_reset_q <= 1'b0;
      count_bit_q    <= 1'b0;
      retries_q      <= 8'd0;
    end else if (advance) begin
      state_q        <= state_d;
      remote_reset_q <= remote_reset_d;
      count_bit_q    <= count_bit_d;
      retries_q      <= retries_d;
    end
  end

  // Next-state and command decode.
  always_comb begin
    link_state_e  st;
    frame_cmd_e   frame;
    timer_cmd_e   timer;
    send_done_e   done;
    keepalive_e   ka;
    link_notice_e notice;
    logic         unexp;

    st             = state_q;
    frame          = FR_NONE;
    timer          = TM_NONE;
    done           = SD_NONE;
    ka             = KA_NONE;
    notice         = LN_NONE;
    unexp          = 1'b0;
    remote_reset_d = remote_reset_q;
    count_bit_d    = count_bit_q;
    retries_d      = retries_q;

    case (state_q)
      ST_IDLE: begin
        if (s1_event_q == EV_SEND_UNCONF) begin
          frame = FR_UNCONF;
          st    = ST_UNCONF_TXW;
        end else if (s1_event_q == EV_SEND_CONF) begin
          retries_d = max_retries_q;
          if (remote_reset_q) begin
            frame = FR_CONF;
            st    = ST_DATA_TXW;
          end else begin
            frame = FR_RESET;
            st    = ST_RESET_TXW;
          end
        end else if (s1_event_q == EV_REQ_STATUS) begin
          frame = FR_STATUS;
          ka    = KA_INIT;
          st    = ST_STATUS_TXW;
        end else begin
          unexp = 1'b1;
        end
      end
      ST_UNCONF_TXW: begin
        if (s1_event_q == EV_TX_DONE) begin
          // Success matters only once the last segment has gone out.
          if (s1_more_q) begin
            frame = FR_UNCONF;
          end else begin
            done = s1_success_q ? SD_OK : SD_FAIL;
            st   = ST_IDLE;
          end
        end else begin
          unexp = 1'b1;
        end
      end
      ST_RESET_TXW, ST_DATA_TXW: begin
        if (s1_event_q == EV_TX_DONE) begin
          if (s1_success_q) begin
            timer = TM_START;
            st    = (state_q == ST_RESET_TXW) ? ST_RESET_WAIT : ST_DATA_WAIT;
          end else begin
            done = SD_FAIL;
            st   = ST_IDLE;
          end
        end else begin
          unexp = 1'b1;
        end
      end
      ST_STATUS_TXW: begin
        if (s1_event_q == EV_TX_DONE) begin
          if (s1_success_q) begin
            timer = TM_START;
            st    = ST_STATUS_WAIT;
          end else begin
            ka = KA_FAILED;
            st = ST_IDLE;
          end
        end else begin
          unexp = 1'b1;
        end
      end
      ST_RESET_WAIT: begin
        if (s1_event_q == EV_ACK) begin
          // The remote link is now reset; confirmed data starts with count bit 1.
          remote_reset_d = 1'b1;
          count_bit_d    = 1'b1;
          timer          = TM_CANCEL;
          frame          = FR_CONF;
          notice         = LN_RESET;
          st             = ST_DATA_TXW;
        end else if (s1_event_q == EV_NACK) begin
          timer = TM_CANCEL;
          done  = SD_FAIL;
          st    = ST_IDLE;
        end else if (s1_event_q == EV_TIMEOUT) begin
          if (retries_q != 8'd0) begin
            retries_d = retries_q - 8'd1;
            frame     = FR_RESET;
            st        = ST_RESET_TXW;
          end else begin
            done = SD_FAIL;
            st   = ST_IDLE;
          end
        end else begin
          unexp = 1'b1;
        end
      end
      ST_DATA_WAIT: begin
        if (s1_event_q == EV_ACK) begin
          count_bit_d = !count_bit_q;
          timer       = TM_CANCEL;
          if (s1_more_q) begin
            frame = FR_CONF;
            st    = ST_DATA_TXW;
          end else begin
            done = SD_OK;
            st   = ST_IDLE;
          end
        end else if (s1_event_q == EV_NACK) begin
          notice = LN_UNRESET;
          timer  = TM_CANCEL;
          if (s1_full_q) begin
            done = SD_FAIL;
            st   = ST_IDLE;
          end else begin
            retries_d = max_retries_q;
            frame     = FR_RESET;
            st        = ST_RESET_TXW;
          end
        end else if (s1_event_q == EV_TIMEOUT) begin
          if (retries_q != 8'd0) begin
            retries_d = retries_q - 8'd1;
            frame     = FR_CONF;
            st        = ST_DATA_TXW;
          end else begin
            notice = LN_UNRESET;
            done   = SD_FAIL;
            st     = ST_IDLE;
          end
        end else begin
          unexp = 1'b1;
        end
      end
      ST_STATUS_WAIT: begin
        if (s1_event_q == EV_NACK || s1_event_q == EV_NOT_SUPP) begin
          timer = TM_CANCEL;
          ka    = KA_FAILED;
          st    = ST_IDLE;
        end else if (s1_event_q == EV_LINK_STATUS) begin
          timer = TM_CANCEL;
          ka    = KA_COMPLETE;
          st    = ST_IDLE;
        end else if (s1_event_q == EV_TIMEOUT) begin
          ka = KA_TIMED_OUT;
          st = ST_IDLE;
        end else begin
          unexp = 1'b1;
        end
      end
      default: begin
        unexp = 1'b1;
      end
    endcase

    state_d                 = st;
    res_d.state_after       = st;
    res_d.frame_cmd         = frame;
    // The count bit goes out only with a confirmed data frame.
    res_d.frame_count_bit   = (frame == FR_CONF) ? count_bit_d : 1'b0;
    res_d.timer_cmd         = timer;
    res_d.send_done         = done;
    res_d.keepalive_event   = ka;
    res_d.link_notice       = notice;
    res_d.unexpected        = unexp;
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign state_after_o     = res_q.state_after;
  assign frame_cmd_o       = res_q.frame_cmd;
  assign frame_count_bit_o = res_q.frame_count_bit;
  assign timer_cmd_o       = res_q.timer_cmd;
  assign send_done_o       = res_q.send_done;
  assign keepalive_event_o = res_q.keepalive_event;
  assign link_notice_o     = res_q.link_notice;
  assign unexpected_o      = res_q.unexpected;

`ifndef SYNTHESIS
  // A presented command always reports the state the controller now holds.
  a_state_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.state_after == state_q))
    else $error("state_after differs from controller state");

  // An unhandled event issues no command of any kind.
  a_unexpected_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.unexpected) |->
      (res_q.frame_cmd == FR_NONE && res_q.timer_cmd == TM_NONE &&
       res_q.send_done == SD_NONE && res_q.keepalive_event == KA_NONE &&
       res_q.link_notice == LN_NONE))
    else $error("unexpected event produced a command");

  // Controller state only moves when an event is decoded.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(state_q) && $stable(retries_q) && $stable(count_bit_q)))
    else $error("controller state changed without an event");
`endif

endmodule
